>>> hw/rtl/fdfr_pkg.sv
// ----------------------------------------------------------------------------
// fdfr_pkg
// Shared constants and types for the flash download frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package fdfr_pkg;

    // frame constants
    localparam logic [7:0] MAGIC_BYTE  = 8'h69;
    localparam int         CHUNK_BYTES = 4096;
    localparam int         BLOCK_SHIFT = 12;
    localparam int         LEN_W       = 13;
    localparam logic [31:0] BLOCK_STEP = 32'd1 << BLOCK_SHIFT;

    // result kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_COMMIT  = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_LEN_ERR = 3'd4;
    localparam logic [2:0] KIND_SUM_ERR = 3'd5;

    // one result item
    typedef struct packed {
        logic [2:0]       event_kind;
        logic [31:0]      flash_address;
        logic [7:0]       data_value;
        logic [LEN_W-1:0] chunk_bytes;
        logic [31:0]      sum_value;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/fdfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// fdfr_frame_fsm
// Frame parser: session state and the result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fdfr_frame_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_rx_byte,
    output fdfr_pkg::t_result     o_result
);

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_OFFSET = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    logic [2:0]                    r_phase, n_phase;
    logic [fdfr_pkg::LEN_W-1:0]    r_idx, n_idx;
    logic [31:0]                   r_field, n_field;
    logic [31:0]                   r_block_base, n_block_base;
    logic [fdfr_pkg::LEN_W-1:0]    r_cur_len, n_cur_len;
    logic [31:0]                   r_chunk_sum, n_chunk_sum;
    logic [31:0]                   r_session_sum, n_session_sum;
    logic [31:0]                   r_session_len, n_session_len;
    logic                          r_halted, n_halted;

    logic [31:0]                   w_word;
    logic                          w_word_done;
    logic [fdfr_pkg::LEN_W-1:0]    w_idx_inc;
    fdfr_pkg::t_result             w_res;

    // little-endian word assembly, one byte per transfer
    assign w_word      = r_field | ({24'd0, i_rx_byte} << {r_idx[1:0], 3'b000});
    assign w_word_done = (r_idx[1:0] == 2'd3);
    assign w_idx_inc   = r_idx + 1'b1;

    // next state and result
    always_comb begin
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_field       = r_field;
        n_block_base  = r_block_base;
        n_cur_len     = r_cur_len;
        n_chunk_sum   = r_chunk_sum;
        n_session_sum = r_session_sum;
        n_session_len = r_session_len;
        n_halted      = r_halted;
        w_res         = '0;
        w_res.event_kind = fdfr_pkg::KIND_NONE;
        if (!r_halted) begin
            case (r_phase)
                PH_OFFSET: begin
                    n_field = w_word;
                    n_idx   = w_idx_inc;
                    if (w_word_done) begin
                        n_idx        = '0;
                        n_block_base = w_word;
                        n_field      = '0;
                        n_phase      = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    n_field = w_word;
                    n_idx   = w_idx_inc;
                    if (w_word_done) begin
                        n_idx   = '0;
                        n_field = '0;
                        if (w_word > 32'(fdfr_pkg::CHUNK_BYTES)) begin
                            w_res.event_kind = fdfr_pkg::KIND_LEN_ERR;
                            n_halted         = 1'b1;
                        end else if (w_word == 32'd0) begin
                            w_res.event_kind    = fdfr_pkg::KIND_DONE;
                            w_res.flash_address = r_session_len;
                            w_res.sum_value     = r_session_sum;
                            n_phase             = PH_MAGIC;
                        end else begin
                            n_cur_len   = w_word[fdfr_pkg::LEN_W-1:0];
                            n_chunk_sum = '0;
                            n_phase     = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    w_res.event_kind    = fdfr_pkg::KIND_DATA;
                    w_res.flash_address = r_block_base + 32'(r_idx);
                    w_res.data_value    = i_rx_byte;
                    n_chunk_sum         = r_chunk_sum + 32'(i_rx_byte);
                    n_idx               = w_idx_inc;
                    if (w_idx_inc >= r_cur_len) begin
                        n_idx   = '0;
                        n_field = '0;
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_field = w_word;
                    n_idx   = w_idx_inc;
                    if (w_word_done) begin
                        n_idx   = '0;
                        n_field = '0;
                        if (w_word == r_chunk_sum) begin
                            w_res.event_kind    = fdfr_pkg::KIND_COMMIT;
                            w_res.flash_address = r_block_base;
                            w_res.chunk_bytes   = r_cur_len;
                            n_session_len = r_session_len + 32'(r_cur_len);
                            n_session_sum = r_session_sum + r_chunk_sum;
                            n_block_base  = r_block_base + fdfr_pkg::BLOCK_STEP;
                            n_phase       = PH_LENGTH;
                        end else begin
                            w_res.event_kind = fdfr_pkg::KIND_SUM_ERR;
                            n_halted         = 1'b1;
                        end
                    end
                end
                default: begin
                    // hunting for the magic byte; unused codes land here too
                    n_phase = PH_MAGIC;
                    if (i_rx_byte == fdfr_pkg::MAGIC_BYTE) begin
                        n_session_sum = '0;
                        n_session_len = '0;
                        n_idx         = '0;
                        n_field       = '0;
                        n_phase       = PH_OFFSET;
                    end
                end
            endcase
        end
    end

    assign o_result = w_res;

    // state registers, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_idx         <= '0;
            r_field       <= '0;
            r_block_base  <= '0;
            r_cur_len     <= '0;
            r_chunk_sum   <= '0;
            r_session_sum <= '0;
            r_session_len <= '0;
            r_halted      <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_idx         <= n_idx;
            r_field       <= n_field;
            r_block_base  <= n_block_base;
            r_cur_len     <= n_cur_len;
            r_chunk_sum   <= n_chunk_sum;
            r_session_sum <= n_session_sum;
            r_session_len <= n_session_len;
            r_halted      <= n_halted;
        end
    end

    // an error halt holds until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    // nothing but empty results once halted
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_halted) |-> (w_res.event_kind == fdfr_pkg::KIND_NONE))
        else $error("result produced while halted");

    // data index stays inside the chunk
    a_data_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_idx < r_cur_len))
        else $error("data index beyond chunk length");

    // word fields count at most four bytes
    a_word_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OFFSET || r_phase == PH_LENGTH || r_phase == PH_CHECK)
        |-> (r_idx < 13'd4))
        else $error("word byte index out of range");

endmodule

`default_nettype wire

>>> hw/rtl/flash_download_frame_receiver.sv
// ----------------------------------------------------------------------------
// flash_download_frame_receiver
// Parses a framed flash download byte stream into data, commit and status
// results.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  input    | in        | i_valid / o_stall   | i_rx_byte
//  result   | out       | o_valid / i_stall   | o_event_kind, o_flash_address,
//           |           |                     | o_data_value, o_chunk_bytes,
//           |           |                     | o_sum_value
//
//  Every accepted byte gives exactly one result, kind none included.
//  One byte per cycle sustained while i_stall is low; o_valid rises once the
//  input transfer has passed the input register, then the result register.
//  The parser update and result logic sit between those two registers.
//  Reset is synchronous and clears the session state and both valid flags.
//  A stalled result holds; the input register still takes a byte behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_download_frame_receiver (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_stall,
    input  wire logic [7:0]                 i_rx_byte,
    output      logic                       o_valid,
    input  wire logic                       i_stall,
    output      logic [2:0]                 o_event_kind,
    output      logic [31:0]                o_flash_address,
    output      logic [7:0]                 o_data_value,
    output      logic [fdfr_pkg::LEN_W-1:0] o_chunk_bytes,
    output      logic [31:0]                o_sum_value
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    fdfr_pkg::t_result r_out;
    fdfr_pkg::t_result w_res;
    logic              w_out_adv;
    logic              w_fire;
    logic              w_in_take;

    // pipeline flow control
    assign w_out_adv = !r_out_valid || !i_stall;
    assign w_fire    = r_in_valid && w_out_adv;
    assign o_stall   = r_in_valid && !w_out_adv;
    assign w_in_take = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take || w_fire) begin
            r_in_valid <= w_in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame parser
    fdfr_frame_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_rx_byte (r_in_byte),
        .o_result  (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out.event_kind;
    assign o_flash_address = r_out.flash_address;
    assign o_data_value    = r_out.data_value;
    assign o_chunk_bytes   = r_out.chunk_bytes;
    assign o_sum_value     = r_out.sum_value;

    // a held result is not lost under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_out))
        else $error("stalled result payload changed");

    // a parsed byte always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("parsed byte produced no result");

endmodule

`default_nettype wire

>>> sim/tb_flash_download_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_flash_download_frame_receiver
// Streams framed download sessions into the receiver: start offsets near
// zero and near the top of the address space, chunks from one byte up to a
// few hundred bytes, empty sessions and noise between sessions. The run ends
// on one broken frame: a bad length word or a bad checksum. A cycle-level
// decoder predicts one result per accepted byte. Results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_flash_download_frame_receiver;

    // driver queue markers
    localparam int HOLD_FOR_DRAIN = -1;
    localparam int NEXT_IDLE_MODE = -2;
    localparam int RANDOM_BYTES   = 400;

    // decoder phases
    typedef enum logic [2:0] {
        ST_SYNC    = 3'd0,
        ST_ORIGIN  = 3'd1,
        ST_LEN     = 3'd2,
        ST_PAYLOAD = 3'd3,
        ST_SUM     = 3'd4
    } t_frame_phase;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       i_valid   = 1'b0;
    logic [7:0]                 i_rx_byte = 8'h00;
    logic                       i_stall   = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [2:0]                 o_event_kind;
    logic [31:0]                o_flash_address;
    logic [7:0]                 o_data_value;
    logic [fdfr_pkg::LEN_W-1:0] o_chunk_bytes;
    logic [31:0]                o_sum_value;

    // stimulus and expectation stores
    int                frame_bytes[$];
    fdfr_pkg::t_result expected_events[$];
    int                error_count = 0;
    int                idle_mode   = 0;
    int                noise_count = 0;
    bit                byte_taken  = 1'b0;
    fdfr_pkg::t_result predicted;
    fdfr_pkg::t_result seen;

    // decoder state
    t_frame_phase     phase          = ST_SYNC;
    logic [12:0]      field_index    = '0;
    logic [31:0]      word_acc       = '0;
    logic [31:0]      start_offset   = '0;
    logic [12:0]      chunk_len      = '0;
    logic [19:0]      blocks_done    = '0;
    logic [31:0]      chunk_total    = '0;
    logic [31:0]      session_total  = '0;
    logic [31:0]      session_bytes  = '0;
    logic             halted         = 1'b0;

    flash_download_frame_receiver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_flash_address (o_flash_address),
        .o_data_value    (o_data_value),
        .o_chunk_bytes   (o_chunk_bytes),
        .o_sum_value     (o_sum_value)
    );

    always #5 i_clk = ~i_clk;

    // little-endian word assembly, true once four bytes are in
    function automatic logic gather_word_byte(input logic [7:0] b);
        word_acc    = word_acc | (32'(b) << (8 * field_index[1:0]));
        field_index = field_index + 13'd1;
        if (field_index >= 13'd4) begin
            field_index = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] block_address();
        return start_offset + (32'(blocks_done) << fdfr_pkg::BLOCK_SHIFT);
    endfunction

    // predicts the result of one received byte and advances the decoder
    task automatic decode_frame_byte(input logic [7:0] b, output fdfr_pkg::t_result r);
        r = '0;
        r.event_kind = fdfr_pkg::KIND_NONE;
        if (!halted) begin
            case (phase)
                ST_ORIGIN: begin
                    if (gather_word_byte(b)) begin
                        start_offset = word_acc;
                        word_acc     = '0;
                        phase        = ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (gather_word_byte(b)) begin
                        if (word_acc > 32'(fdfr_pkg::CHUNK_BYTES)) begin
                            r.event_kind = fdfr_pkg::KIND_LEN_ERR;
                            halted       = 1'b1;
                        end else if (word_acc == '0) begin
                            r.event_kind    = fdfr_pkg::KIND_DONE;
                            r.flash_address = session_bytes;
                            r.sum_value     = session_total;
                            phase           = ST_SYNC;
                        end else begin
                            chunk_len   = word_acc[12:0];
                            chunk_total = '0;
                            field_index = '0;
                            phase       = ST_PAYLOAD;
                        end
                        word_acc = '0;
                    end
                end
                ST_PAYLOAD: begin
                    r.event_kind    = fdfr_pkg::KIND_DATA;
                    r.flash_address = block_address() + 32'(field_index);
                    r.data_value    = b;
                    chunk_total     = chunk_total + 32'(b);
                    field_index     = field_index + 13'd1;
                    if (field_index >= chunk_len) begin
                        field_index = '0;
                        word_acc    = '0;
                        phase       = ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (gather_word_byte(b)) begin
                        if (word_acc == chunk_total) begin
                            r.event_kind    = fdfr_pkg::KIND_COMMIT;
                            r.flash_address = block_address();
                            r.chunk_bytes   = chunk_len;
                            session_bytes   = session_bytes + 32'(chunk_len);
                            session_total   = session_total + chunk_total;
                            blocks_done     = blocks_done + 20'd1;
                            phase           = ST_LEN;
                        end else begin
                            r.event_kind = fdfr_pkg::KIND_SUM_ERR;
                            halted       = 1'b1;
                        end
                        word_acc = '0;
                    end
                end
                default: begin
                    phase = ST_SYNC;
                    if (b == fdfr_pkg::MAGIC_BYTE) begin
                        blocks_done   = '0;
                        session_total = '0;
                        session_bytes = '0;
                        field_index   = '0;
                        word_acc      = '0;
                        phase         = ST_ORIGIN;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // stimulus builders
    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(int'(w[8*i +: 8]));
    endtask

    task automatic push_noise(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == fdfr_pkg::MAGIC_BYTE);
            frame_bytes.push_back(int'(b));
            noise_count++;
        end
    endtask

    // length word, data and checksum; a nonzero skew corrupts the checksum
    task automatic push_chunk(input int len, input logic [31:0] skew);
        logic [31:0] total;
        logic [7:0]  b;
        total = '0;
        push_word(32'(len));
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            total += 32'(b);
            frame_bytes.push_back(int'(b));
        end
        push_word(total + skew);
    endtask

    task automatic push_session_head(input logic [31:0] offset);
        frame_bytes.push_back(int'(fdfr_pkg::MAGIC_BYTE));
        push_word(offset);
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return '0;
            2:       return 32'hFFFF_F000 + 32'($urandom_range(0, 4095));
            default: return 32'($urandom_range(0, 65535));
        endcase
    endfunction

    // input side: accepted bytes go through the decoder
    // result side: each accepted result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken = 1'b0;
        end else begin
            byte_taken = i_valid && !o_stall;
            if (byte_taken) begin
                decode_frame_byte(i_rx_byte, predicted);
                expected_events.push_back(predicted);
            end
            if (o_valid && !i_stall) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d",
                             $time, o_event_kind);
                    error_count++;
                end else begin
                    seen = expected_events.pop_front();
                    check_field("event_kind", 32'(seen.event_kind), 32'(o_event_kind));
                    check_field("flash_address", seen.flash_address, o_flash_address);
                    check_field("data_value", 32'(seen.data_value), 32'(o_data_value));
                    check_field("chunk_bytes", 32'(seen.chunk_bytes), 32'(o_chunk_bytes));
                    check_field("sum_value", seen.sum_value, o_sum_value);
                end
            end
        end
    end

    // driver: new byte or gap at the falling edge, held while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            while (frame_bytes.size() != 0 && frame_bytes[0] == NEXT_IDLE_MODE) begin
                void'(frame_bytes.pop_front());
                idle_mode++;
            end
            case (idle_mode)
                0:       i_stall <= ($urandom_range(0, 99) < 47);
                1:       i_stall <= ($urandom_range(0, 99) < 15);
                default: i_stall <= 1'b0;
            endcase
            if (!i_valid || byte_taken) begin
                if (frame_bytes.size() != 0 && frame_bytes[0] == HOLD_FOR_DRAIN &&
                    expected_events.size() == 0 && !i_valid)
                    void'(frame_bytes.pop_front());
                if (frame_bytes.size() == 0 || frame_bytes[0] < 0)
                    i_valid <= 1'b0;
                else if ((idle_mode == 0 && $urandom_range(0, 99) < 15) ||
                         (idle_mode == 1 && $urandom_range(0, 99) < 47))
                    i_valid <= 1'b0;
                else begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= 8'(frame_bytes.pop_front());
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int start_size;
        int chunk_count;
        int len;

        // directed: ignored bytes, offset that wraps, extreme data bytes
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        push_session_head(32'hFFFF_FFFE);
        frame_bytes.push_back(32'(1));
        frame_bytes.delete(frame_bytes.size() - 1);
        push_word(32'd1);
        frame_bytes.push_back(8'hFF);
        push_word(32'h0000_00FF);
        push_word(32'd3);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h7F);
        push_word(32'h0000_00FF);
        push_word(32'd0);

        // random sessions, idling modes switch at thirds
        start_size = frame_bytes.size();
        while (frame_bytes.size() - start_size - noise_count < RANDOM_BYTES) begin
            if (idle_mode == 0 &&
                frame_bytes.size() - start_size - noise_count > RANDOM_BYTES / 3) begin
                frame_bytes.push_back(NEXT_IDLE_MODE);
                frame_bytes.push_back(HOLD_FOR_DRAIN);
                idle_mode = 1;
            end else if (idle_mode == 1 &&
                frame_bytes.size() - start_size - noise_count > 2 * RANDOM_BYTES / 3) begin
                frame_bytes.push_back(NEXT_IDLE_MODE);
                idle_mode = 2;
            end
            push_noise($urandom_range(0, 3));
            push_session_head(pick_offset());
            chunk_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            for (int c = 0; c < chunk_count; c++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300)
                                                  : $urandom_range(1, 16);
                push_chunk(len, '0);
            end
            push_word(32'd0);
        end
        idle_mode = 0;

        // one larger chunk between two small ones
        push_session_head(pick_offset());
        push_chunk($urandom_range(1, 16), '0);
        push_chunk($urandom_range(100, 160), '0);
        push_chunk($urandom_range(1, 16), '0);
        push_word(32'd0);

        // broken frame halts the receiver for the rest of the run
        push_session_head(pick_offset());
        push_chunk($urandom_range(1, 16), '0);
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       push_word(32'(fdfr_pkg::CHUNK_BYTES + 1));
                1:       push_word(32'hFFFF_FFFF);
                2:       push_word(32'h8000_0000);
                default: push_word(32'($urandom_range(fdfr_pkg::CHUNK_BYTES + 1,
                                                      32'h7FFF_FFFF)));
            endcase
        end else begin
            push_chunk($urandom_range(1, 16), 32'($urandom_range(1, 32'hFFFF)));
        end
        frame_bytes.push_back(int'(fdfr_pkg::MAGIC_BYTE));
        push_noise(8);

        // synchronous reset, released at a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (frame_bytes.size() != 0 || i_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/fdfr_pkg.sv
hw/rtl/fdfr_frame_fsm.sv
hw/rtl/flash_download_frame_receiver.sv
sim/tb_flash_download_frame_receiver.sv
